[rtl/assert_macros.svh]
// Assertion helpers. The user scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is active.
`define OMV_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is active.
`define OMV_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/omv_pkg.sv]
package omv_pkg;

    // Fixed field widths of the stream payloads
    localparam int SAMPLE_IN_W  = 16;
    localparam int COUNT_OUT_W  = 16;
    localparam int MEAN_OUT_W   = 16;
    localparam int VAR_W        = 31;

    // Squared-deviation accumulator, unsigned Q18.30
    localparam int SUM_W        = 48;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a wide quotient to the variance field
    function automatic logic [VAR_W-1:0] sat_var(input logic [SUM_W-1:0] q);
        logic [VAR_W-1:0] r;
        if (q > SUM_W'(VAR_MAX))
        begin
            r = VAR_MAX;
        end
        else
        begin
            r = q[VAR_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/omv_in_if.sv]
interface omv_in_if
    import omv_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_IN_W-1:0] sample;
    logic                          start_new;

    modport source (output valid, output sample, output start_new, input ready);
    modport sink   (input valid, input sample, input start_new, output ready);
endinterface

[rtl/omv_out_if.sv]
interface omv_out_if
    import omv_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic        [COUNT_OUT_W-1:0] sample_count;
    logic signed [MEAN_OUT_W-1:0]  running_mean;
    logic        [VAR_W-1:0]       population_variance;
    logic        [VAR_W-1:0]       sample_variance;
    logic                          stats_valid;
    logic                          count_full;

    modport source (
        output valid, output sample_count, output running_mean,
        output population_variance, output sample_variance,
        output stats_valid, output count_full, input ready
    );
    modport sink (
        input valid, input sample_count, input running_mean,
        input population_variance, input sample_variance,
        input stats_valid, input count_full, output ready
    );
endinterface

[rtl/omv_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module omv_divider
    import omv_pkg::*;
#(
    parameter int NUM_W = SUM_W,
    parameter int DEN_W = COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output div_stat_t        stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fit;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fit     = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            // shift the quotient bit in where the dividend bit left
            num_reg <= {num_reg[NUM_W-2:0], fit};
            rem_reg <= fit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/online_mean_variance_core.sv]
// Online mean and variance over a stream of signed fixed-point samples.
//
// Channels: "samples" (sink) carries one sample and a start_new bit per beat;
// "stats" (source) returns one beat per sample with the count, the mean,
// sum/count and sum/(count-1), a valid flag for count >= 2 and a flag that
// marks a sample dropped because the count is saturated.
//
// Timing: one sample is in flight at a time, so a new beat is taken only
// once the previous one has been through every step. A count of one skips
// the sample variance, and a dropped sample skips the mean and sum update.
// The rate is set by the shared 48-step restoring divider, which runs up to
// three divisions per sample (mean step, population and sample variance).
//
// Stalls: the result sits in an output register. The core takes the next
// sample while that beat waits and only holds at the final step if the
// previous result is still not taken.
//
// Reset: count, mean and squared-deviation sum clear to zero, no result
// is pending, and samples.ready is high from reset on.
module online_mean_variance_core
    import omv_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    omv_in_if.sink     samples,
    omv_out_if.source  stats
);

`include "assert_macros.svh"

    localparam int EXT_W  = (SAMPLE_BITS > SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
    localparam int DLT_W  = SAMPLE_BITS + 1;
    localparam int PROD_W = 2 * DLT_W;
    localparam int ACC_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN_START,
        S_MEAN_WAIT,
        S_PRODUCT,
        S_ACCUM,
        S_POP_START,
        S_POP_WAIT,
        S_SAMP_START,
        S_SAMP_WAIT,
        S_FINISH
    } state_t;

    state_t                        state_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic signed [SAMPLE_BITS-1:0] mean_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [DLT_W-1:0]       delta_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          full_reg;
    logic [VAR_W-1:0]              pop_reg;
    logic [VAR_W-1:0]              samp_reg;

    logic                          out_valid_reg;
    logic [COUNT_OUT_W-1:0]        out_count_reg;
    logic signed [MEAN_OUT_W-1:0]  out_mean_reg;
    logic [VAR_W-1:0]              out_pop_reg;
    logic [VAR_W-1:0]              out_samp_reg;
    logic                          out_stats_valid_reg;
    logic                          out_full_reg;

    // Input decode
    logic                          accept;
    logic [EXT_W-1:0]              raw_ext;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic [COUNT_BITS-1:0]         count_eff;
    logic signed [SAMPLE_BITS-1:0] mean_eff;

    // Shared divider
    logic                          div_start;
    logic [SUM_W-1:0]              div_num;
    logic [COUNT_BITS-1:0]         div_den;
    logic [SUM_W-1:0]              div_quot;
    div_stat_t                     div_stat;

    // Datapath
    logic [DLT_W-1:0]              delta_mag;
    logic signed [DLT_W-1:0]       mean_step;
    logic signed [DLT_W-1:0]       mean_sum;
    logic signed [DLT_W-1:0]       delta2;
    logic signed [PROD_W-1:0]      prod_s;
    logic [ACC_W-1:0]              acc;
    logic                          load_out;

    assign accept    = samples.valid && samples.ready;
    assign raw_ext   = EXT_W'($unsigned(samples.sample));
    assign x_in      = $signed(raw_ext[SAMPLE_BITS-1:0]);
    assign count_eff = samples.start_new ? '0 : count_reg;
    assign mean_eff  = samples.start_new ? '0 : mean_reg;

    assign delta_mag = delta_reg[DLT_W-1] ? DLT_W'(-delta_reg) : DLT_W'(delta_reg);
    assign mean_step = delta_reg[DLT_W-1] ? -$signed(div_quot[DLT_W-1:0])
                                          : $signed(div_quot[DLT_W-1:0]);
    assign mean_sum  = DLT_W'(mean_reg) + mean_step;
    assign delta2    = DLT_W'(x_reg) - DLT_W'(mean_reg);
    assign prod_s    = PROD_W'(delta_reg) * PROD_W'(delta2);
    assign acc       = ACC_W'(sum_reg) + ACC_W'(prod_reg);

    assign load_out  = (state_reg == S_FINISH) && (!out_valid_reg || stats.ready);

    // Divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = sum_reg;
        div_den   = count_reg;
        unique case (state_reg)
            S_MEAN_START:
            begin
                div_start = 1'b1;
                div_num   = SUM_W'(delta_mag);
            end
            S_POP_START:
            begin
                div_start = 1'b1;
            end
            S_SAMP_START:
            begin
                div_start = 1'b1;
                div_den   = count_reg - 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    omv_divider #(
        .NUM_W (SUM_W),
        .DEN_W (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // Sequencer, statistics state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            count_reg           <= '0;
            mean_reg            <= '0;
            sum_reg             <= '0;
            x_reg               <= '0;
            delta_reg           <= '0;
            prod_reg            <= '0;
            full_reg            <= 1'b0;
            pop_reg             <= '0;
            samp_reg            <= '0;
            out_valid_reg       <= 1'b0;
            out_count_reg       <= '0;
            out_mean_reg        <= '0;
            out_pop_reg         <= '0;
            out_samp_reg        <= '0;
            out_stats_valid_reg <= 1'b0;
            out_full_reg        <= 1'b0;
        end
        else
        begin
            // drop the result beat once taken, unless a new one loads in its place
            if (stats.ready && out_valid_reg && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg <= x_in;
                        if (count_eff == COUNT_MAX)
                        begin
                            // saturated: keep the statistics, report them again
                            full_reg  <= 1'b1;
                            state_reg <= S_POP_START;
                        end
                        else
                        begin
                            full_reg  <= 1'b0;
                            count_reg <= count_eff + 1'b1;
                            mean_reg  <= mean_eff;
                            if (samples.start_new)
                            begin
                                sum_reg <= '0;
                            end
                            delta_reg <= DLT_W'(x_in) - DLT_W'(mean_eff);
                            state_reg <= S_MEAN_START;
                        end
                    end
                end
                S_MEAN_START:
                begin
                    state_reg <= S_MEAN_WAIT;
                end
                S_MEAN_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        // quotient truncates toward zero via sign-magnitude
                        mean_reg  <= mean_sum[SAMPLE_BITS-1:0];
                        state_reg <= S_PRODUCT;
                    end
                end
                S_PRODUCT:
                begin
                    prod_reg  <= $unsigned(prod_s);
                    state_reg <= S_ACCUM;
                end
                S_ACCUM:
                begin
                    if (acc > ACC_W'(SUM_MAX))
                    begin
                        sum_reg <= SUM_MAX;
                    end
                    else
                    begin
                        sum_reg <= acc[SUM_W-1:0];
                    end
                    state_reg <= S_POP_START;
                end
                S_POP_START:
                begin
                    state_reg <= S_POP_WAIT;
                end
                S_POP_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        pop_reg <= sat_var(div_quot);
                        if (count_reg >= COUNT_TWO)
                        begin
                            state_reg <= S_SAMP_START;
                        end
                        else
                        begin
                            samp_reg  <= '0;
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_SAMP_START:
                begin
                    state_reg <= S_SAMP_WAIT;
                end
                S_SAMP_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        samp_reg  <= sat_var(div_quot);
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    // hold until the output register is free
                    if (load_out)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_count_reg       <= COUNT_OUT_W'(count_reg);
                        out_mean_reg        <= MEAN_OUT_W'(mean_reg);
                        out_pop_reg         <= pop_reg;
                        out_samp_reg        <= samp_reg;
                        out_stats_valid_reg <= (count_reg >= COUNT_TWO);
                        out_full_reg        <= full_reg;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign samples.ready             = (state_reg == S_IDLE);
    assign stats.valid               = out_valid_reg;
    assign stats.sample_count        = out_count_reg;
    assign stats.running_mean        = out_mean_reg;
    assign stats.population_variance = out_pop_reg;
    assign stats.sample_variance     = out_samp_reg;
    assign stats.stats_valid         = out_stats_valid_reg;
    assign stats.count_full          = out_full_reg;

    `OMV_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy,
        "divider started while busy")
    `OMV_ASSERT_NXT(a_fresh_count_one, accept && samples.start_new,
        count_reg == COUNT_BITS'(1), "start_new did not restart the count at one")
    `OMV_ASSERT_IMP(a_svar_zero_low_count, load_out && (count_reg < COUNT_TWO),
        samp_reg == '0, "sample variance nonzero with fewer than two samples")
    `OMV_ASSERT_IMP(a_no_accept_while_busy, div_stat.busy, !samples.ready,
        "input ready while the divider runs")

endmodule

[tb/sv/online_mean_variance_core_tb.sv]
module online_mean_variance_core_tb
    import omv_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Build the core with its default count width.
    localparam int DUT_COUNT_BITS = COUNT_BITS_DEF;
    localparam logic [DUT_COUNT_BITS-1:0] COUNT_LIMIT = {DUT_COUNT_BITS{1'b1}};

    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_AFTER   = 40;     // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 400;    // linger time after the last result
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic signed [SAMPLE_IN_W-1:0] sample;
        logic                          start_new;
    } sample_beat_t;

    typedef struct {
        logic        [COUNT_OUT_W-1:0] count;
        logic signed [MEAN_OUT_W-1:0]  mean;
        logic        [VAR_W-1:0]       pop_var;
        logic        [VAR_W-1:0]       samp_var;
        logic                          stats_valid;
        logic                          count_full;
    } stats_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    omv_in_if  samples_if ();
    omv_out_if stats_if ();

    online_mean_variance_core #(
        .COUNT_BITS  (DUT_COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS_DEF)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .stats   (stats_if)
    );

    // 10 ns period, first rising edge at 5 ns.
    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    // Beats waiting to be offered, and stats beats predicted but not yet seen.
    sample_beat_t sample_backlog[$];
    stats_beat_t  stats_due[$];

    // Private copy of the core's accumulators.
    logic        [DUT_COUNT_BITS-1:0] tally;
    logic signed [SAMPLE_IN_W-1:0]    mean_q;
    logic        [SUM_W-1:0]          dev_sum;

    int mismatches   = 0;
    int results_seen = 0;
    int cycle_count  = 0;

    // Apply one sample to the running statistics and return the stats beat it
    // should produce. The mean moves by delta/count truncated toward zero; the
    // product delta*delta2 is never negative since the new mean lies between
    // the old mean and the sample.
    function automatic stats_beat_t welford_update(input logic signed [SAMPLE_IN_W-1:0] x,
                                                   input logic fresh);
        stats_beat_t      r;
        longint           delta;
        longint           delta2;
        longint           step;
        logic [63:0]      prod;
        logic [SUM_W-1:0] quot;
        r.count_full = 1'b0;
        if (fresh)
        begin
            tally   = '0;
            mean_q  = '0;
            dev_sum = '0;
        end
        if (tally == COUNT_LIMIT)
        begin
            // Saturated count: drop the sample, keep the statistics.
            r.count_full = 1'b1;
        end
        else
        begin
            tally  = tally + 1'b1;
            delta  = longint'(x) - longint'(mean_q);
            step   = delta / longint'(tally);
            mean_q = SAMPLE_IN_W'(longint'(mean_q) + step);
            delta2 = longint'(x) - longint'(mean_q);
            prod   = 64'(delta * delta2);
            if (prod > 64'(SUM_MAX) - 64'(dev_sum))
            begin
                dev_sum = SUM_MAX;
            end
            else
            begin
                dev_sum = dev_sum + SUM_W'(prod);
            end
        end
        r.count   = COUNT_OUT_W'(tally);
        r.mean    = mean_q;
        quot      = dev_sum / SUM_W'(tally);
        r.pop_var = (quot > SUM_W'(VAR_MAX)) ? VAR_MAX : quot[VAR_W-1:0];
        if (tally >= 2)
        begin
            quot          = dev_sum / SUM_W'(tally - 1'b1);
            r.samp_var    = (quot > SUM_W'(VAR_MAX)) ? VAR_MAX : quot[VAR_W-1:0];
            r.stats_valid = 1'b1;
        end
        else
        begin
            r.samp_var    = '0;
            r.stats_valid = 1'b0;
        end
        return r;
    endfunction

    // Mix of extremes, values clustered near zero (small deltas, truncation)
    // and the full range.
    function automatic logic signed [SAMPLE_IN_W-1:0] draw_sample();
        int v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            1, 2:    v = int'($urandom_range(0, 511)) - 256;
            default: v = int'($urandom_range(0, 65535));
        endcase
        return SAMPLE_IN_W'(v);
    endfunction

    task automatic queue_sample(input logic signed [SAMPLE_IN_W-1:0] value, input logic fresh);
        sample_beat_t b;
        b.sample    = value;
        b.start_new = fresh;
        sample_backlog.push_back(b);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer backlog beats in bursts with random gaps. A new beat is
    // presented only once the current one is taken, and every taken beat
    // is run through the predictor at the edge that accepts it.
    // ------------------------------------------------------------------
    int           burst_left;
    int           gap_left;
    sample_beat_t next_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_if.valid     <= 1'b0;
            samples_if.sample    <= '0;
            samples_if.start_new <= 1'b0;
            burst_left           <= 1;
            gap_left             <= 0;
        end
        else
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                stats_due.push_back(welford_update(samples_if.sample, samples_if.start_new));
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (gap_left != 0)
                begin
                    // Idle between bursts.
                    gap_left         <= gap_left - 1;
                    samples_if.valid <= 1'b0;
                end
                else if (sample_backlog.size() != 0)
                begin
                    next_beat            = sample_backlog.pop_front();
                    samples_if.valid     <= 1'b1;
                    samples_if.sample    <= next_beat.sample;
                    samples_if.start_new <= next_beat.start_new;
                    if (burst_left <= 1)
                    begin
                        // Close the burst; about a third of them run on with no gap.
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off: once enough results have come back, refuse results for
    // a long stretch so the output register and the core fill and the
    // sample channel stalls while the driver keeps offering.
    // ------------------------------------------------------------------
    int   hold_left;
    logic hold_armed;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && results_seen >= HOLD_AFTER)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a rotating 16-bit pattern that is redrawn
    // whenever pattern_age wraps, sometimes all ones (no stalls), sometimes sparse.
    // Bit 0 is forced at each redraw so the pattern always holds a ready slot.
    // ------------------------------------------------------------------
    logic [15:0] stall_pattern;
    logic [5:0]  pattern_age;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_if.ready <= 1'b0;
            stall_pattern  <= '1;
            pattern_age    <= '0;
        end
        else
        begin
            stats_if.ready <= (hold_left == 0) && stall_pattern[0];
            pattern_age    <= pattern_age + 1'b1;
            if (pattern_age == 6'd63)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= '1;
                    1:       stall_pattern <= 16'($urandom()) | 16'h0001;
                    2:       stall_pattern <= 16'($urandom() | $urandom()) | 16'h0001;
                    default: stall_pattern <= 16'($urandom() & $urandom()) | 16'h0001;
                endcase
            end
            else
            begin
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every accepted stats beat against the oldest
    // prediction, field by field. Report the first few, count the rest.
    // ------------------------------------------------------------------
    stats_beat_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && stats_if.valid && stats_if.ready)
        begin
            results_seen <= results_seen + 1;
            if (stats_due.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("[%0t] stats beat with nothing outstanding: cnt=%0d mean=%0d",
                             $realtime, stats_if.sample_count, stats_if.running_mean);
                end
            end
            else
            begin
                oldest = stats_due.pop_front();
                if (stats_if.sample_count        !== oldest.count       ||
                    stats_if.running_mean        !== oldest.mean        ||
                    stats_if.population_variance !== oldest.pop_var     ||
                    stats_if.sample_variance     !== oldest.samp_var    ||
                    stats_if.stats_valid         !== oldest.stats_valid ||
                    stats_if.count_full          !== oldest.count_full)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("[%0t] stats mismatch", $realtime);
                        $display("  exp cnt=%0d mean=%0d pvar=%0d svar=%0d vld=%0b full=%0b",
                                 oldest.count, oldest.mean, oldest.pop_var,
                                 oldest.samp_var, oldest.stats_valid, oldest.count_full);
                        $display("  got cnt=%0d mean=%0d pvar=%0d svar=%0d vld=%0b full=%0b",
                                 stats_if.sample_count, stats_if.running_mean,
                                 stats_if.population_variance, stats_if.sample_variance,
                                 stats_if.stats_valid, stats_if.count_full);
                    end
                end
            end
        end
    end

    // Watchdog: give up well past the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int produced;
        int run_len;
        rst_n                = 1'b0;
        samples_if.valid     = 1'b0;
        samples_if.sample    = '0;
        samples_if.start_new = 1'b0;
        stats_if.ready       = 1'b0;
        tally                = '0;
        mean_q               = '0;
        dev_sum              = '0;

        // Directed: a lone sample, the widest possible swing between two
        // samples, the extremes, and zero and its neighbors.
        queue_sample(16'sd32767, 1'b1);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd32767, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd1, 1'b0);
        // Fresh start with the opposite extreme order.
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(16'sd32767, 1'b0);
        // Single sample, then back-to-back fresh starts.
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sd100, 1'b1);
        queue_sample(-16'sd100, 1'b1);
        // Two equal extreme samples after a fresh start at -100.
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        // Small negative deltas: quotient must truncate toward zero.
        queue_sample(16'sd0, 1'b1);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(-16'sd2, 1'b0);
        // Small positive deltas.
        queue_sample(-16'sd1, 1'b1);
        queue_sample(16'sd1, 1'b0);
        queue_sample(16'sd2, 1'b0);
        queue_sample(16'sd32767, 1'b1);
        queue_sample(16'sd32767, 1'b0);
        queue_sample(-16'sd32768, 1'b0);

        // Random: runs that open with start_new, mostly short with an
        // occasional long one for larger counts. A few stray start_new bits
        // break runs in the middle.
        produced = 0;
        while (produced < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                run_len = $urandom_range(100, 200);
            end
            else
            begin
                run_len = $urandom_range(1, 40);
            end
            if (run_len > RANDOM_ITEMS - produced)
            begin
                run_len = RANDOM_ITEMS - produced;
            end
            for (int k = 0; k < run_len; k++)
            begin
                queue_sample(draw_sample(), (k == 0) || ($urandom_range(0, 39) == 0));
            end
            produced = produced + run_len;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge to stay clear of the driver's updates.
        while (sample_backlog.size() != 0 || samples_if.valid)
        begin
            @(negedge clk);
        end
        while (stats_due.size() != 0)
        begin
            @(negedge clk);
        end
        // Linger to catch any stray beat.
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
